// ===== design/bpc_pkg.sv =====
`default_nettype none

package bpc_pkg;

    localparam int BUTTONS = 4;
    localparam int CNT_W = 16;
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] DOUBLE_HOLD_RESET = 16'd400;
    localparam logic [CNT_W-1:0] LONG_HOLD_RESET = 16'd750;
    localparam logic [CNT_W-1:0] DOUBLE_GAP_RESET = 16'd500;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DOUBLE_HOLD = 2'd0;
    localparam logic [1:0] REG_LONG_HOLD = 2'd1;
    localparam logic [1:0] REG_DOUBLE_GAP = 2'd2;

    typedef enum logic [1:0] {
        CLS_IDLE = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_LONG = 2'd2,
        CLS_DOUBLE = 2'd3
    } class_t;

    typedef struct packed {
        logic [CNT_W-1:0] double_hold_ticks;
        logic [CNT_W-1:0] long_hold_ticks;
        logic [CNT_W-1:0] double_gap_ticks;
    } cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== design/bpc_lane.sv =====
`default_nettype none

module bpc_lane (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         advance,
    input  wire logic         pressed,
    input  wire bpc_pkg::cfg_t cfg,
    output bpc_pkg::class_t   press_class
);

    bpc_pkg::class_t class_reg;
    bpc_pkg::class_t class_next;
    logic [bpc_pkg::CNT_W-1:0] hold_reg;
    logic [bpc_pkg::CNT_W-1:0] hold_next;
    logic [bpc_pkg::CNT_W-1:0] gap_reg;
    logic [bpc_pkg::CNT_W-1:0] gap_next;
    logic [bpc_pkg::CNT_W-1:0] hold_inc;
    logic [bpc_pkg::CNT_W-1:0] gap_inc;

    assign hold_inc = bpc_pkg::sat_inc(hold_reg);
    assign gap_inc = bpc_pkg::sat_inc(gap_reg);

    // class transitions
    always_comb
    begin
        class_next = class_reg;
        if (pressed)
        begin
            case (class_reg)
                bpc_pkg::CLS_IDLE:
                begin
                    class_next = (gap_inc > cfg.double_gap_ticks) ?
                                 bpc_pkg::CLS_SHORT : bpc_pkg::CLS_DOUBLE;
                end
                bpc_pkg::CLS_SHORT:
                begin
                    if (hold_inc > cfg.long_hold_ticks)
                        class_next = bpc_pkg::CLS_LONG;
                end
                bpc_pkg::CLS_DOUBLE:
                begin
                    if (hold_inc > cfg.double_hold_ticks)
                        class_next = bpc_pkg::CLS_LONG;
                end
                default:
                begin
                    class_next = class_reg;
                end
            endcase
        end
        else
        begin
            class_next = bpc_pkg::CLS_IDLE;
        end
    end

    // hold and gap counters
    always_comb
    begin
        hold_next = hold_reg;
        gap_next = gap_inc;
        if (pressed)
        begin
            // a fresh press restarts the hold count
            hold_next = (class_reg == bpc_pkg::CLS_IDLE) ? '0 : hold_inc;
        end
        else if (class_reg != bpc_pkg::CLS_IDLE)
        begin
            gap_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= bpc_pkg::CLS_IDLE;
            hold_reg <= '0;
            gap_reg <= bpc_pkg::CNT_MAX;
        end
        else if (advance)
        begin
            class_reg <= class_next;
            hold_reg <= hold_next;
            gap_reg <= gap_next;
        end
    end

    assign press_class = class_reg;

endmodule

`default_nettype wire

// ===== design/button_press_classifier.sv =====
// button press classifier, four buttons
// input channel: in_valid / in_stall carry pressed_mask, one sample tick per
// request, bit k high while button k is pressed
// output channel: out_valid / out_stall carry button_classes, two bits per
// button (0 idle, 1 short, 2 long, 3 double), one result per request
// the class of each button is updated in the cycle the request is taken and
// the result appears on the next cycle, held in the lane class registers;
// one request per cycle is sustained while the receiver does not stall
// when the receiver stalls, the result is held and in_stall rises while it
// waits; a new request is taken in the same cycle the held result leaves
// thresholds are set through the apb port: 0x0 double hold ticks,
// 0x4 long hold ticks, 0x8 double gap ticks (16 bits each, read back)
// write thresholds only while the block is idle
// reset: all buttons idle, hold counts zero, gap counts saturated so the
// first press is short, thresholds 400 / 750 / 500, no result pending
`default_nettype none

module button_press_classifier (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bpc_pkg::DATA_W-1:0]    pwdata,
    output logic      [bpc_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [bpc_pkg::BUTTONS-1:0]   pressed_mask,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [2*bpc_pkg::BUTTONS-1:0] button_classes
);

    bpc_pkg::cfg_t cfg_reg;
    logic out_valid_reg;
    logic advance;
    logic cfg_write;
    logic [1:0] reg_index;

    assign pready = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.double_hold_ticks <= bpc_pkg::DOUBLE_HOLD_RESET;
            cfg_reg.long_hold_ticks <= bpc_pkg::LONG_HOLD_RESET;
            cfg_reg.double_gap_ticks <= bpc_pkg::DOUBLE_GAP_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                bpc_pkg::REG_DOUBLE_HOLD:
                    cfg_reg.double_hold_ticks <= pwdata[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_LONG_HOLD:
                    cfg_reg.long_hold_ticks <= pwdata[bpc_pkg::CNT_W-1:0];
                bpc_pkg::REG_DOUBLE_GAP:
                    cfg_reg.double_gap_ticks <= pwdata[bpc_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            bpc_pkg::REG_DOUBLE_HOLD:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}},
                          cfg_reg.double_hold_ticks};
            bpc_pkg::REG_LONG_HOLD:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}},
                          cfg_reg.long_hold_ticks};
            bpc_pkg::REG_DOUBLE_GAP:
                prdata = {{(bpc_pkg::DATA_W-bpc_pkg::CNT_W){1'b0}},
                          cfg_reg.double_gap_ticks};
            default:
                prdata = '0;
        endcase
    end

    // the lane class registers double as the result register
    assign in_stall = out_valid_reg && out_stall;
    assign advance = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;

    for (genvar b = 0; b < bpc_pkg::BUTTONS; b++)
    begin : g_lane
        bpc_pkg::class_t lane_class;

        bpc_lane u_lane (
            .clk         (clk),
            .rst_n       (rst_n),
            .advance     (advance),
            .pressed     (pressed_mask[b]),
            .cfg         (cfg_reg),
            .press_class (lane_class)
        );

        assign button_classes[2*b +: 2] = lane_class;
    end

endmodule

`default_nettype wire

// ===== sim/tb_button_press_classifier.sv =====
`timescale 1ns / 1ps

module tb_button_press_classifier;

    import bpc_pkg::*;

    localparam int LIMIT_CYCLES = 4_000_000;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    class press_class_tracker;
        logic [CNT_W-1:0] double_hold;
        logic [CNT_W-1:0] long_hold;
        logic [CNT_W-1:0] double_gap;
        class_t cls [BUTTONS];
        logic [CNT_W-1:0] hold_cnt [BUTTONS];
        logic [CNT_W-1:0] gap_cnt [BUTTONS];
        logic [2*BUTTONS-1:0] expected_classes [$];
        int errors;

        function new();
            double_hold = DOUBLE_HOLD_RESET;
            long_hold = LONG_HOLD_RESET;
            double_gap = DOUBLE_GAP_RESET;
            for (int b = 0; b < BUTTONS; b++)
            begin
                cls[b] = CLS_IDLE;
                hold_cnt[b] = '0;
                gap_cnt[b] = CNT_MAX;
            end
            errors = 0;
        endfunction

        function void set_threshold(input logic [1:0] idx, input logic [DATA_W-1:0] value);
            case (idx)
                REG_DOUBLE_HOLD: double_hold = value[CNT_W-1:0];
                REG_LONG_HOLD:   long_hold = value[CNT_W-1:0];
                REG_DOUBLE_GAP:  double_gap = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_tick(input logic [BUTTONS-1:0] mask);
            logic [2*BUTTONS-1:0] classes;
            classes = '0;
            for (int b = 0; b < BUTTONS; b++)
            begin
                if (gap_cnt[b] != CNT_MAX)
                    gap_cnt[b] = gap_cnt[b] + 1'b1;
                if (mask[b])
                begin
                    if (hold_cnt[b] != CNT_MAX)
                        hold_cnt[b] = hold_cnt[b] + 1'b1;
                    case (cls[b])
                        CLS_IDLE:
                        begin
                            cls[b] = (gap_cnt[b] > double_gap) ? CLS_SHORT : CLS_DOUBLE;
                            hold_cnt[b] = '0;
                        end
                        CLS_SHORT:
                            if (hold_cnt[b] > long_hold)
                                cls[b] = CLS_LONG;
                        CLS_DOUBLE:
                            if (hold_cnt[b] > double_hold)
                                cls[b] = CLS_LONG;
                        default: ;
                    endcase
                end
                else if (cls[b] != CLS_IDLE)
                begin
                    cls[b] = CLS_IDLE;
                    gap_cnt[b] = '0;
                end
                classes[2*b +: 2] = cls[b];
            end
            expected_classes.push_back(classes);
        endfunction

        task check_result(input logic [2*BUTTONS-1:0] got);
            logic [2*BUTTONS-1:0] want;
            if (expected_classes.size() == 0)
            begin
                report_mismatch($sformatf("result %h with nothing expected", got));
                return;
            end
            want = expected_classes.pop_front();
            if (got !== want)
                report_mismatch($sformatf("button_classes %h, expected %h", got, want));
        endtask

        task report_mismatch(input string msg);
            errors++;
            $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        function int pending();
            return expected_classes.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    wire logic [DATA_W-1:0] prdata;
    wire logic pready;
    logic in_valid;
    wire logic in_stall;
    logic [BUTTONS-1:0] pressed_mask;
    wire logic out_valid;
    logic out_stall;
    wire logic [2*BUTTONS-1:0] button_classes;

    press_class_tracker tracker;
    bit send_gaps;
    bit stall_gaps;
    int cycle_count;

    button_press_classifier dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pressed_mask   (pressed_mask),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .button_classes (button_classes)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= LIMIT_CYCLES)
            begin
                $display("tb_button_press_classifier: done, errors");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.check_result(button_classes);
            if (in_valid && !in_stall)
                tracker.predict_tick(pressed_mask);
        end
    end

    // receiver stalls in random bursts
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_gaps && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        tracker.set_threshold(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [CNT_W-1:0] dhold, input logic [CNT_W-1:0] lhold,
                                  input logic [CNT_W-1:0] dgap);
        apb_write(REG_DOUBLE_HOLD, {16'h0, dhold});
        apb_write(REG_LONG_HOLD, {16'h0, lhold});
        apb_write(REG_DOUBLE_GAP, {16'h0, dgap});
    endtask

    task automatic send_tick(input logic [BUTTONS-1:0] mask);
        in_valid <= 1'b1;
        pressed_mask <= mask;
        do
            @(posedge clk);
        while (in_stall);
        if (send_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_run(input logic [BUTTONS-1:0] mask, input int count);
        repeat (count) send_tick(mask);
    endtask

    // let every result come back before touching the thresholds
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    // press and release runs sized around the thresholds, with some noise
    task automatic run_presses(input int count);
        logic [BUTTONS-1:0] level;
        logic [BUTTONS-1:0] mask;
        int run_left [BUTTONS];
        int hold_span;
        int gap_span;
        hold_span = (tracker.long_hold > tracker.double_hold) ? int'(tracker.long_hold)
                                                               : int'(tracker.double_hold);
        hold_span = ((hold_span > 40) ? 40 : hold_span) + 4;
        gap_span = ((int'(tracker.double_gap) > 40) ? 40 : int'(tracker.double_gap)) + 4;
        level = '0;
        for (int b = 0; b < BUTTONS; b++)
            run_left[b] = $urandom_range(0, 3);
        for (int i = 0; i < count; i++)
        begin
            for (int b = 0; b < BUTTONS; b++)
            begin
                if (run_left[b] == 0)
                begin
                    level[b] = ~level[b];
                    run_left[b] = $urandom_range(1, level[b] ? hold_span : gap_span);
                end
                run_left[b]--;
            end
            mask = level;
            if ($urandom_range(0, 9) == 0)
                mask = BUTTONS'($urandom_range(0, 15));
            send_tick(mask);
        end
    endtask

    initial
    begin
        tracker = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        pressed_mask = '0;
        send_gaps = 1'b1;
        stall_gaps = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: first press short, quick re-press double
        send_run(4'h0, 1);
        send_run(4'hF, 1);
        send_run(4'h0, 1);
        send_run(4'h5, 1);
        send_run(4'hA, 1);
        drain();

        // small thresholds, upper bits of a write dropped, unused address ignored
        apb_write(REG_DOUBLE_HOLD, 32'd2);
        apb_write(REG_LONG_HOLD, 32'hABCD_0003);
        apb_write(REG_DOUBLE_GAP, 32'd4);
        apb_write(REG_UNUSED, 32'hFFFF_FFFF);
        send_run(4'hF, 6);
        send_run(4'h0, 2);
        send_run(4'hF, 5);
        send_run(4'h0, 7);
        send_run(4'hF, 2);
        drain();

        // all thresholds at zero
        set_thresholds(16'd0, 16'd0, 16'd0);
        send_run(4'h3, 3);
        send_run(4'h0, 1);
        send_run(4'hC, 2);
        drain();

        // all thresholds at full scale: every press is double and never long
        set_thresholds(CNT_MAX, CNT_MAX, CNT_MAX);
        send_run(4'h0, 1);
        send_run(4'hF, 3);
        send_run(4'h0, 1);
        send_run(4'hF, 1);
        drain();

        // long presses on buttons 0,1 against hold thresholds at and near full scale
        set_thresholds(CNT_MAX, CNT_MAX, 16'd0);
        send_run(4'h0, 1);
        send_run(4'hC, 1);
        send_run(4'h3, 40);
        drain();
        set_thresholds(CNT_MAX, CNT_MAX - 1'b1, CNT_MAX - 1'b1);
        send_run(4'hF, 1);
        drain();

        for (int phase = 0; phase < 7; phase++)
        begin
            if (phase == 3)
                set_thresholds(CNT_W'($urandom_range(0, 65535)),
                               CNT_W'($urandom_range(0, 65535)),
                               CNT_W'($urandom_range(0, 65535)));
            else
                set_thresholds(CNT_W'($urandom_range(0, 24)), CNT_W'($urandom_range(0, 24)),
                               CNT_W'($urandom_range(0, 24)));
            send_gaps = (phase < 6) && ($urandom_range(0, 3) != 0);
            stall_gaps = (phase < 6) && ($urandom_range(0, 3) != 0);
            run_presses(100);
            drain();
        end

        repeat (5) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("tb_button_press_classifier: done, clean");
        else
            $display("tb_button_press_classifier: done, errors");
        $finish;
    end

endmodule
